// ----- sv/pat_pkg.sv -----
package pat_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ID_W    = 16;
    localparam int TAG_W   = 8;
    localparam int STAT_W  = 16;
    localparam int NOW_W   = 31;
    localparam int TMO_W   = 16;
    localparam int DL_W    = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [TMO_W-1:0] TIMEOUT_RST = TMO_W'(30);
    // register index taken from paddr[2]
    localparam logic REG_TIMEOUT = 1'b0;

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_SIGNAL = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_CHECK  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        RC_OK        = 2'd0,
        RC_FULL      = 2'd1,
        RC_NOT_FOUND = 2'd2
    } t_code;

    typedef struct packed {
        logic  load;
        logic  add_wr;
        logic  free_slot;
        logic  rearm;
        logic  idx_inc;
        logic  emit;
        t_code code;
        logic  use_slot;
        logic  stat_clr;
        logic  expired;
        logic  last;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  has_free;
        logic  any_used;
        logic  cur_used;
        logic  cur_match;
        logic  cur_late;
        logic  cur_due;
        logic  idx_end;
        logic  none_after;
        logic  out_free;
    } t_sts;

    typedef struct packed {
        t_code              code;
        logic               notify;
        logic [TAG_W-1:0]   tag;
        logic [STAT_W-1:0]  status;
        logic               expired;
        logic               last;
    } t_rsp;

endpackage

// ----- sv/pat_req_if.sv -----
interface pat_req_if;
    import pat_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic [ID_W-1:0]          message_id;
    logic [TAG_W-1:0]         context_tag;
    logic                     wants_notify;
    logic signed [STAT_W-1:0] clear_status;
    logic [NOW_W-1:0]         now_sec;

    modport source (
        output valid, func, message_id, context_tag, wants_notify, clear_status, now_sec,
        input  ready
    );

    modport sink (
        input  valid, func, message_id, context_tag, wants_notify, clear_status, now_sec,
        output ready
    );

endinterface

// ----- sv/pat_rsp_if.sv -----
interface pat_rsp_if;
    import pat_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               result_code;
    logic                     notify;
    logic [TAG_W-1:0]         done_tag;
    logic signed [STAT_W-1:0] done_status;
    logic                     any_expired;
    logic                     last;

    modport source (
        output valid, result_code, notify, done_tag, done_status, any_expired, last,
        input  ready
    );

    modport sink (
        input  valid, result_code, notify, done_tag, done_status, any_expired, last,
        output ready
    );

endinterface

// ----- sv/pat_cfg.sv -----
module pat_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pat_pkg::PADDR_W-1:0]  paddr,
    input  logic [pat_pkg::PDATA_W-1:0]  pwdata,
    output logic [pat_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [pat_pkg::TMO_W-1:0]    o_timeout
);
    import pat_pkg::*;

    logic [TMO_W-1:0] r_timeout;
    logic             w_sel_tmo;

    assign w_sel_tmo = (paddr[2] == REG_TIMEOUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (psel && penable && pwrite && w_sel_tmo) begin
            r_timeout <= pwdata[TMO_W-1:0];
        end
    end

    assign prdata    = w_sel_tmo ? PDATA_W'(r_timeout) : '0;
    assign pready    = 1'b1;
    assign o_timeout = r_timeout;

endmodule

// ----- sv/pat_dp.sv -----
module pat_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_func,
    input  logic [pat_pkg::ID_W-1:0]    i_message_id,
    input  logic [pat_pkg::TAG_W-1:0]   i_context_tag,
    input  logic                        i_wants_notify,
    input  logic [pat_pkg::STAT_W-1:0]  i_clear_status,
    input  logic [pat_pkg::NOW_W-1:0]   i_now_sec,
    input  logic [pat_pkg::TMO_W-1:0]   i_timeout,
    input  pat_pkg::t_cmd               i_cmd,
    output pat_pkg::t_sts               o_sts,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output pat_pkg::t_rsp               o_out
);
    import pat_pkg::*;

    // latched request
    t_func             r_func;
    logic [ID_W-1:0]   r_id;
    logic [TAG_W-1:0]  r_tag;
    logic              r_want;
    logic [STAT_W-1:0] r_cstat;
    logic [NOW_W-1:0]  r_now;
    logic [DL_W-1:0]   r_horizon;
    logic [SLOT_W-1:0] r_idx;

    // slot table
    logic [SLOTS-1:0]  r_used;
    logic [ID_W-1:0]   r_msg_id   [SLOTS];
    logic [TAG_W-1:0]  r_stag     [SLOTS];
    logic              r_snotify  [SLOTS];
    logic [DL_W-1:0]   r_deadline [SLOTS];

    logic              r_out_valid;
    t_rsp              r_out;

    logic [SLOT_W-1:0] w_free_idx;
    logic              w_has_free;
    logic              w_none_after;
    logic              w_notify;

    always_comb begin
        w_free_idx = '0;
        w_has_free = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_idx = SLOT_W'(i);
                w_has_free = 1'b1;
            end
        end
    end

    always_comb begin
        w_none_after = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            if (i > int'(r_idx) && r_used[i]) begin
                w_none_after = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= t_func'(i_func);
            r_id      <= i_message_id;
            r_tag     <= i_context_tag;
            r_want    <= i_wants_notify;
            r_cstat   <= i_clear_status;
            r_now     <= i_now_sec;
            r_horizon <= DL_W'(i_now_sec) + DL_W'(i_timeout);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.add_wr) begin
            r_used[w_free_idx] <= 1'b1;
        end else if (i_cmd.free_slot) begin
            r_used[r_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) begin
            r_msg_id[w_free_idx]   <= r_id;
            r_stag[w_free_idx]     <= r_tag;
            r_snotify[w_free_idx]  <= r_want;
            r_deadline[w_free_idx] <= r_horizon;
        end else if (i_cmd.rearm) begin
            r_deadline[r_idx] <= r_horizon;
        end
    end

    assign w_notify = i_cmd.use_slot & r_snotify[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.code    <= i_cmd.code;
            r_out.notify  <= w_notify;
            r_out.tag     <= w_notify ? r_stag[r_idx] : '0;
            r_out.status  <= (w_notify && i_cmd.stat_clr) ? r_cstat : '0;
            r_out.expired <= i_cmd.expired;
            r_out.last    <= i_cmd.last;
        end
    end

    always_comb begin
        o_sts.func       = r_func;
        o_sts.has_free   = w_has_free;
        o_sts.any_used   = |r_used;
        o_sts.cur_used   = r_used[r_idx];
        o_sts.cur_match  = (r_msg_id[r_idx] == r_id);
        o_sts.cur_late   = (r_deadline[r_idx] > r_horizon);
        o_sts.cur_due    = (r_deadline[r_idx] <= DL_W'(r_now));
        o_sts.idx_end    = (r_idx == SLOT_W'(SLOTS - 1));
        o_sts.none_after = w_none_after;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- sv/pat_ctrl.sv -----
module pat_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  pat_pkg::t_sts  i_sts,
    output pat_pkg::t_cmd  o_cmd
);
    import pat_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        w_cmd       = '0;
        w_cmd.code  = RC_OK;
        n_state     = r_state;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = ST_BUSY;
                end
            end
            ST_BUSY: begin
                // every step waits for room in the output register
                if (i_sts.out_free) begin
                    unique case (i_sts.func)
                        FN_ADD: begin
                            w_cmd.emit   = 1'b1;
                            w_cmd.last   = 1'b1;
                            w_cmd.add_wr = i_sts.has_free;
                            w_cmd.code   = i_sts.has_free ? RC_OK : RC_FULL;
                            n_state      = ST_IDLE;
                        end
                        FN_SIGNAL: begin
                            if (i_sts.cur_used && i_sts.cur_match) begin
                                w_cmd.emit      = 1'b1;
                                w_cmd.last      = 1'b1;
                                w_cmd.use_slot  = 1'b1;
                                w_cmd.free_slot = 1'b1;
                                n_state         = ST_IDLE;
                            end else if (i_sts.idx_end) begin
                                w_cmd.emit = 1'b1;
                                w_cmd.last = 1'b1;
                                w_cmd.code = RC_NOT_FOUND;
                                n_state    = ST_IDLE;
                            end else begin
                                w_cmd.idx_inc = 1'b1;
                            end
                        end
                        FN_CLEAR: begin
                            if (!i_sts.any_used) begin
                                // empty table: one plain word
                                w_cmd.emit = 1'b1;
                                w_cmd.last = 1'b1;
                                n_state    = ST_IDLE;
                            end else if (i_sts.cur_used) begin
                                w_cmd.emit      = 1'b1;
                                w_cmd.use_slot  = 1'b1;
                                w_cmd.stat_clr  = 1'b1;
                                w_cmd.free_slot = 1'b1;
                                w_cmd.last      = i_sts.none_after;
                                w_cmd.idx_inc   = !i_sts.none_after;
                                if (i_sts.none_after) begin
                                    n_state = ST_IDLE;
                                end
                            end else begin
                                w_cmd.idx_inc = 1'b1;
                            end
                        end
                        FN_CHECK: begin
                            if (i_sts.cur_used && i_sts.cur_late) begin
                                w_cmd.rearm = 1'b1;
                            end
                            if (i_sts.cur_used && !i_sts.cur_late && i_sts.cur_due) begin
                                w_cmd.emit    = 1'b1;
                                w_cmd.last    = 1'b1;
                                w_cmd.expired = 1'b1;
                                n_state       = ST_IDLE;
                            end else if (i_sts.idx_end) begin
                                w_cmd.emit = 1'b1;
                                w_cmd.last = 1'b1;
                                n_state    = ST_IDLE;
                            end else begin
                                w_cmd.idx_inc = 1'b1;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;

endmodule

// ----- sv/pending_ack_tracker.sv -----
// Add answers with one word; signal, clear and check walk the slot table
// one slot per cycle while the output register has room. Clear emits one
// word per used slot, or one plain word on an empty table. One item is in
// work at a time; the output register lets the next item be accepted while
// a word waits. Synchronous active-low reset empties table, timeout to 30.
module pending_ack_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pat_req_if.sink                      i_req,
    pat_rsp_if.source                    o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pat_pkg::PADDR_W-1:0]  paddr,
    input  logic [pat_pkg::PDATA_W-1:0]  pwdata,
    output logic [pat_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import pat_pkg::*;

    logic [TMO_W-1:0] w_timeout;
    t_cmd             w_cmd;
    t_sts             w_sts;
    t_rsp             w_out;
    logic             w_out_valid;

    pat_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_timeout (w_timeout)
    );

    pat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    pat_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_func         (i_req.func),
        .i_message_id   (i_req.message_id),
        .i_context_tag  (i_req.context_tag),
        .i_wants_notify (i_req.wants_notify),
        .i_clear_status (i_req.clear_status),
        .i_now_sec      (i_req.now_sec),
        .i_timeout      (w_timeout),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (w_out_valid),
        .o_out          (w_out)
    );

    assign o_rsp.valid       = w_out_valid;
    assign o_rsp.result_code = w_out.code;
    assign o_rsp.notify      = w_out.notify;
    assign o_rsp.done_tag    = w_out.tag;
    assign o_rsp.done_status = w_out.status;
    assign o_rsp.any_expired = w_out.expired;
    assign o_rsp.last        = w_out.last;

endmodule

// ----- bench/pending_ack_tracker_test.sv -----
`timescale 1ns / 100ps

module pending_ack_tracker_test;
    import pat_pkg::*;

    typedef struct packed {
        t_func                    func;
        logic [ID_W-1:0]          id;
        logic [TAG_W-1:0]         tag;
        logic                     want;
        logic signed [STAT_W-1:0] cstat;
        logic [NOW_W-1:0]         now;
    } t_cmd_word;

    localparam logic [PADDR_W-1:0] TMO_ADDR = {REG_TIMEOUT, 2'b00};

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    pat_req_if cmd_bus ();
    pat_rsp_if ack_bus ();

    pending_ack_tracker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cmd_bus),
        .o_rsp   (ack_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the slot table
    logic [TMO_W-1:0] tmo_cfg;
    bit               tbl_used [SLOTS];
    logic [ID_W-1:0]  tbl_id   [SLOTS];
    logic [TAG_W-1:0] tbl_tag  [SLOTS];
    bit               tbl_ntf  [SLOTS];
    logic [DL_W-1:0]  tbl_dl   [SLOTS];

    t_cmd_word cmd_pend_q [$];
    t_rsp      reply_q    [$];

    bit          cmd_taken;
    bit          idle_on;
    int unsigned src_gap;
    int unsigned snk_gap;
    int          mism_cnt;
    int          word_cnt;
    int          full_cnt;
    int          exp_cnt;
    int          cfg_cnt;
    int          func_cnt [4];

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic track_item(input t_cmd_word w);
        t_rsp          r;
        t_rsp          held;
        bit            found;
        bit            have;
        logic [DL_W:0] horizon;
        r       = '0;
        r.code  = RC_OK;
        r.last  = 1'b1;
        held    = '0;
        found   = 1'b0;
        have    = 1'b0;
        horizon = (DL_W+1)'(w.now) + (DL_W+1)'(tmo_cfg);
        func_cnt[w.func]++;
        case (w.func)
            FN_ADD: begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (!found && !tbl_used[k]) begin
                        tbl_used[k] = 1'b1;
                        tbl_id[k]   = w.id;
                        tbl_tag[k]  = w.tag;
                        tbl_ntf[k]  = w.want;
                        tbl_dl[k]   = DL_W'(w.now) + DL_W'(tmo_cfg);
                        found       = 1'b1;
                    end
                end
                if (!found) begin
                    r.code = RC_FULL;
                    full_cnt++;
                end
                reply_q.push_back(r);
            end
            FN_SIGNAL: begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (!found && tbl_used[k] && tbl_id[k] == w.id) begin
                        tbl_used[k] = 1'b0;
                        found       = 1'b1;
                        r.notify    = tbl_ntf[k];
                        r.tag       = tbl_ntf[k] ? tbl_tag[k] : '0;
                    end
                end
                if (!found)
                    r.code = RC_NOT_FOUND;
                reply_q.push_back(r);
            end
            FN_CLEAR: begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (tbl_used[k]) begin
                        if (have)
                            reply_q.push_back(held);
                        held        = '0;
                        held.code   = RC_OK;
                        held.notify = tbl_ntf[k];
                        held.tag    = tbl_ntf[k] ? tbl_tag[k] : '0;
                        held.status = tbl_ntf[k] ? w.cstat : '0;
                        have        = 1'b1;
                        tbl_used[k] = 1'b0;
                    end
                end
                if (have) begin
                    held.last = 1'b1;
                    reply_q.push_back(held);
                end else begin
                    reply_q.push_back(r);
                end
            end
            FN_CHECK: begin
                // stop the walk at the first passed deadline
                for (int k = 0; k < SLOTS; k++) begin
                    if (!found && tbl_used[k]) begin
                        if ({1'b0, tbl_dl[k]} > horizon)
                            tbl_dl[k] = horizon[DL_W-1:0];
                        else if (tbl_dl[k] <= DL_W'(w.now))
                            found = 1'b1;
                    end
                end
                r.expired = found;
                if (found)
                    exp_cnt++;
                reply_q.push_back(r);
            end
        endcase
    endtask

    // monitor and predictor
    always @(posedge i_clk) begin
        t_rsp      got;
        t_rsp      want;
        t_cmd_word w;
        cmd_taken <= i_rst_n && cmd_bus.valid && cmd_bus.ready;
        if (i_rst_n && ack_bus.valid && ack_bus.ready) begin
            got.code    = t_code'(ack_bus.result_code);
            got.notify  = ack_bus.notify;
            got.tag     = ack_bus.done_tag;
            got.status  = ack_bus.done_status;
            got.expired = ack_bus.any_expired;
            got.last    = ack_bus.last;
            if (reply_q.size() == 0) begin
                mism_cnt++;
                $display("%0t: unexpected reply word code %0d notify %b tag %h status %h",
                         $time, got.code, got.notify, got.tag, got.status,
                         " expired %b last %b", got.expired, got.last);
            end else begin
                want = reply_q.pop_front();
                word_cnt++;
                if (got !== want) begin
                    mism_cnt++;
                    $display("%0t: reply mismatch expected code %0d notify %b tag %h",
                             $time, want.code, want.notify, want.tag,
                             " status %h expired %b last %b",
                             want.status, want.expired, want.last);
                    $display("%0t:                  actual code %0d notify %b tag %h",
                             $time, got.code, got.notify, got.tag,
                             " status %h expired %b last %b",
                             got.status, got.expired, got.last);
                end
            end
        end
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            w.func  = t_func'(cmd_bus.func);
            w.id    = cmd_bus.message_id;
            w.tag   = cmd_bus.context_tag;
            w.want  = cmd_bus.wants_notify;
            w.cstat = cmd_bus.clear_status;
            w.now   = cmd_bus.now_sec;
            track_item(w);
        end
    end

    // driver: command words and reply backpressure
    always @(negedge i_clk) begin
        t_cmd_word w;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
            ack_bus.ready <= 1'b0;
        end else begin
            if (cmd_taken) begin
                void'(cmd_pend_q.pop_front());
                if (idle_on && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 14);
            end
            if (cmd_bus.valid && !cmd_taken) begin
                // hold the word until accepted
            end else if (src_gap > 0) begin
                src_gap--;
                cmd_bus.valid <= 1'b0;
            end else if (cmd_pend_q.size() > 0) begin
                w = cmd_pend_q[0];
                cmd_bus.func         <= w.func;
                cmd_bus.message_id   <= w.id;
                cmd_bus.context_tag  <= w.tag;
                cmd_bus.wants_notify <= w.want;
                cmd_bus.clear_status <= w.cstat;
                cmd_bus.now_sec      <= w.now;
                cmd_bus.valid        <= 1'b1;
            end else begin
                cmd_bus.valid <= 1'b0;
            end

            if (snk_gap > 0) begin
                snk_gap--;
                ack_bus.ready <= 1'b0;
            end else begin
                ack_bus.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    snk_gap = $urandom_range(1, 14);
            end
        end
    end

    task automatic queue_cmd(input t_func f, input logic [ID_W-1:0] id,
                             input logic [TAG_W-1:0] tag, input logic want,
                             input logic [STAT_W-1:0] cstat,
                             input logic [NOW_W-1:0] now);
        t_cmd_word w;
        w.func  = f;
        w.id    = id;
        w.tag   = tag;
        w.want  = want;
        w.cstat = cstat;
        w.now   = now;
        cmd_pend_q.push_back(w);
    endtask

    task automatic wait_drained();
        while (cmd_pend_q.size() != 0 || cmd_bus.valid || reply_q.size() != 0)
            @(posedge i_clk);
        repeat (2 * SLOTS + 4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_cnt++;
    endtask

    initial begin
        logic [ID_W-1:0]  id_pool [8];
        logic [NOW_W-1:0] gen_now;
        logic [TMO_W-1:0] tmo_val;
        int unsigned      sel;

        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.func         = FN_ADD;
        cmd_bus.message_id   = '0;
        cmd_bus.context_tag  = '0;
        cmd_bus.wants_notify = 1'b0;
        cmd_bus.clear_status = '0;
        cmd_bus.now_sec      = '0;
        ack_bus.ready        = 1'b0;
        cmd_taken            = 1'b0;
        idle_on              = 1'b1;
        src_gap              = 0;
        snk_gap              = 0;
        mism_cnt             = 0;
        word_cnt             = 0;
        full_cnt             = 0;
        exp_cnt              = 0;
        cfg_cnt              = 0;
        func_cnt             = '{default: 0};
        tmo_cfg              = TIMEOUT_RST;
        for (int k = 0; k < SLOTS; k++)
            tbl_used[k] = 1'b0;
        for (int k = 0; k < 8; k++)
            id_pool[k] = ID_W'($urandom);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table answers
        queue_cmd(FN_SIGNAL, 16'h0000, 8'h00, 1'b0, 16'h0000, 31'd0);
        queue_cmd(FN_CHECK,  16'h0000, 8'h00, 1'b0, 16'h0000, 31'd0);
        queue_cmd(FN_CLEAR,  16'h0000, 8'h00, 1'b0, 16'h8000, 31'd0);
        // deadline past 31 bits, then rearm and the expiry boundary
        queue_cmd(FN_ADD,    16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 31'h7FFF_FFFF);
        queue_cmd(FN_CHECK,  16'h0000, 8'h00, 1'b0, 16'h0000, 31'd1000);
        queue_cmd(FN_CHECK,  16'h0000, 8'h00, 1'b0, 16'h0000, 31'd1029);
        queue_cmd(FN_CHECK,  16'h0000, 8'h00, 1'b0, 16'h0000, 31'd1030);
        queue_cmd(FN_ADD,    16'h0000, 8'h00, 1'b0, 16'h0000, 31'd0);
        queue_cmd(FN_SIGNAL, 16'h0000, 8'h00, 1'b0, 16'h0000, 31'd0);
        queue_cmd(FN_SIGNAL, 16'h0000, 8'h00, 1'b0, 16'h0000, 31'd0);
        queue_cmd(FN_SIGNAL, 16'hFFFF, 8'h00, 1'b0, 16'h0000, 31'd0);
        // fill every slot with repeated ids, overflow, lowest match, clear all
        for (int k = 0; k <= SLOTS; k++)
            queue_cmd(FN_ADD, ID_W'(16'h00A0 + k % 3), TAG_W'(k * 17 + 1), k[0],
                      16'h0000, NOW_W'(5000 + k));
        queue_cmd(FN_SIGNAL, 16'h00A1, 8'h00, 1'b0, 16'h0000, 31'd0);
        queue_cmd(FN_CLEAR,  16'h0000, 8'h00, 1'b0, 16'h7FFF, 31'd0);

        gen_now = NOW_W'($urandom);
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0:       tmo_val = '0;
                1:       tmo_val = '1;
                2:       tmo_val = TMO_W'(1);
                4:       tmo_val = TIMEOUT_RST;
                default: tmo_val = TMO_W'($urandom);
            endcase
            cfg_write(TMO_ADDR, PDATA_W'(tmo_val));
            tmo_cfg = tmo_val;
            if (ph == 5)
                idle_on = 1'b0;
            for (int n = 0; n < 25; n++) begin
                t_cmd_word w;
                sel = $urandom_range(0, 19);
                case (sel)
                    0:       gen_now = NOW_W'($urandom);
                    1:       gen_now = gen_now - NOW_W'($urandom_range(0, 50));
                    2:       gen_now = gen_now + NOW_W'($urandom_range(0, 70000));
                    3:       gen_now = '1;
                    4:       gen_now = '0;
                    default: gen_now = gen_now + NOW_W'($urandom_range(0, 12));
                endcase
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    w.func = FN_ADD;
                else if (sel < 70)
                    w.func = FN_SIGNAL;
                else if (sel < 92)
                    w.func = FN_CHECK;
                else
                    w.func = FN_CLEAR;
                w.id    = ($urandom_range(0, 3) != 0) ? id_pool[$urandom_range(0, 7)]
                                                      : ID_W'($urandom);
                w.tag   = TAG_W'($urandom);
                w.want  = 1'($urandom_range(0, 1));
                w.cstat = STAT_W'($urandom);
                w.now   = gen_now;
                cmd_pend_q.push_back(w);
            end
        end
        wait_drained();

        $display("covered %0d commands (add %0d, signal %0d, clear %0d, check %0d), %0d words",
                 func_cnt[FN_ADD] + func_cnt[FN_SIGNAL] + func_cnt[FN_CLEAR] +
                 func_cnt[FN_CHECK], func_cnt[FN_ADD], func_cnt[FN_SIGNAL],
                 func_cnt[FN_CLEAR], func_cnt[FN_CHECK], word_cnt);
        $display("table full %0d times, expiry seen %0d times, %0d timeout settings",
                 full_cnt, exp_cnt, cfg_cnt);
        if (mism_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
